// ===== hw/rtl/slps_pkg.sv =====
// Shared constants and helper functions for the scatter list block-shift core.
package slps_pkg;

  localparam int ADDR_W    = 64;
  localparam int LEN_W     = 32;
  localparam int SHIFT_W   = 6;
  localparam int BSHIFT_W  = 5;
  localparam int COUNT_W   = 52;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 64;

  // Running shift before any break lowers it.
  localparam logic [SHIFT_W-1:0] MAX_SHIFT = SHIFT_W'(31);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PAGE_SHIFT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VIRT_START     = CFG_IDX_W'(1);

  localparam logic [BSHIFT_W-1:0] MIN_PAGE_SHIFT_RST = BSHIFT_W'(12);

  // Trailing zero count; result is meaningless for v == 0.
  function automatic logic [SHIFT_W-1:0] low_zeros(input logic [ADDR_W-1:0] v);
    logic [SHIFT_W-1:0] n;
    n = '0;
    for (int i = ADDR_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        n = SHIFT_W'(i);
      end
    end
    return n;
  endfunction

  // Mask of the low s bits.
  function automatic logic [ADDR_W-1:0] low_mask(input logic [SHIFT_W-1:0] s);
    return ~({ADDR_W{1'b1}} << s);
  endfunction

endpackage

// ===== hw/rtl/slps_if.sv =====
// Handshake channels for scatter entries and block-shift results.
interface slps_seg_if;
  logic                          valid;
  logic                          ready;
  logic [slps_pkg::ADDR_W-1:0]   seg_addr;
  logic [slps_pkg::LEN_W-1:0]    seg_len;
  logic                          last_seg;

  modport source (output valid, seg_addr, seg_len, last_seg, input ready);
  modport sink   (input valid, seg_addr, seg_len, last_seg, output ready);
endinterface

interface slps_res_if;
  logic                          valid;
  logic                          ready;
  logic [slps_pkg::BSHIFT_W-1:0] xlat_shift;
  logic [slps_pkg::COUNT_W-1:0]  mtt_count;
  logic                          count_valid;
  logic                          misaligned;

  modport source (output valid, xlat_shift, mtt_count, count_valid, misaligned, input ready);
  modport sink   (input valid, xlat_shift, mtt_count, count_valid, misaligned, output ready);
endinterface

// ===== hw/rtl/scatter_list_translation_page_size_core.sv =====
// Top level: block-shift and translation entry count for one scattered memory region.
//
// Scatter entries of a region arrive one word per cycle on seg while seg.ready
// is high; the word with last_seg set closes the region and yields one result
// word on res. Words without last_seg give no result. Every entry is taken
// when seg.ready is high: the running state (shift, end of the current
// contiguous run, summed length, region start) is updated by two 64-bit adds,
// the break compare, the shift compares and three trailing-zero counts.
// Closing a region goes through a snapshot register, a padding-add register
// and an output register that takes the shift and remainder test, so seg keeps
// accepting one word per cycle while a finished result waits; seg.ready drops
// only when all three finishing stages are full and res is stalled.
// Configuration (min_page_shift, virt_start) is written through
// wr_en/wr_index/wr_data and takes effect on the next entry.
module scatter_list_translation_page_size_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [slps_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [slps_pkg::CFG_W-1:0]       wr_data,
  slps_seg_if.sink                         seg,
  slps_res_if.source                       res
);

  localparam int AW = slps_pkg::ADDR_W;
  localparam int SW = slps_pkg::SHIFT_W;
  localparam int BW = slps_pkg::BSHIFT_W;

  // Configuration registers
  logic [BW-1:0] min_page_shift;
  logic [AW-1:0] virt_start;

  // Running region state; tot_len is closed runs plus the open run.
  logic          first_pending, first_pending_next;
  logic          stopped, stopped_next;
  logic [SW-1:0] cur_shift, cur_shift_next;
  logic [AW-1:0] run_end, run_end_next;
  logic [AW-1:0] region_start, region_start_next;
  logic [AW-1:0] tot_len, tot_len_next;

  // Finish stage 1: snapshot of the closed region
  logic          b_valid;
  logic          b_stopped;
  logic [SW-1:0] b_shift;
  logic [BW-1:0] b_minsh;
  logic [AW-1:0] b_end;
  logic [AW-1:0] b_tot;
  logic [AW-1:0] b_region;

  // Finish stage 2: padded total
  logic          c_valid;
  logic          c_stopped;
  logic [SW-1:0] c_shift;
  logic [BW-1:0] c_shown;
  logic [AW-1:0] c_total;

  logic o_ready, c_ready, b_ready;
  logic accept;

  assign o_ready   = !res.valid || res.ready;
  assign c_ready   = !c_valid || o_ready;
  assign b_ready   = !b_valid || c_ready;
  assign seg.ready = b_ready;
  assign accept    = seg.valid && seg.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_page_shift <= slps_pkg::MIN_PAGE_SHIFT_RST;
      virt_start     <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        slps_pkg::REG_MIN_PAGE_SHIFT: min_page_shift <= wr_data[BW-1:0];
        slps_pkg::REG_VIRT_START:     virt_start     <= wr_data[AW-1:0];
        default: ;
      endcase
    end
  end

  // Entry datapath
  logic [AW-1:0] len64;
  logic [AW-1:0] diff;
  logic [SW-1:0] tz_diff, tz_addr, tz_end;
  logic [SW-1:0] first_shift, s_addr, s_brk;
  logic          brk;
  logic [AW-1:0] end_sum, tot_sum;

  assign len64   = {{(AW - slps_pkg::LEN_W){1'b0}}, seg.seg_len};
  // Virtual start is page aligned before the compare.
  assign diff    = (virt_start & ~slps_pkg::low_mask({1'b0, min_page_shift})) ^ seg.seg_addr;
  assign tz_diff = slps_pkg::low_zeros(diff);
  assign tz_addr = slps_pkg::low_zeros(seg.seg_addr);
  assign tz_end  = slps_pkg::low_zeros(run_end);

  // All-zero difference keeps the maximum shift.
  assign first_shift = (diff != '0 && tz_diff < slps_pkg::MAX_SHIFT) ?
                       tz_diff : slps_pkg::MAX_SHIFT;

  // A break lowers the shift to the alignment of the new start and old end.
  assign brk    = run_end != seg.seg_addr;
  assign s_addr = (seg.seg_addr != '0 && tz_addr < cur_shift) ? tz_addr : cur_shift;
  assign s_brk  = (run_end != '0 && tz_end < s_addr) ? tz_end : s_addr;

  assign end_sum = ((first_pending || brk) ? seg.seg_addr : run_end) + len64;
  assign tot_sum = (first_pending ? '0 : tot_len) + len64;

  always_comb begin
    first_pending_next = first_pending;
    stopped_next       = stopped;
    cur_shift_next     = cur_shift;
    run_end_next       = run_end;
    region_start_next  = region_start;
    tot_len_next       = tot_len;
    priority if (first_pending) begin
      cur_shift_next     = first_shift;
      region_start_next  = seg.seg_addr;
      run_end_next       = end_sum;
      tot_len_next       = tot_sum;
      stopped_next       = 1'b0;
      first_pending_next = 1'b0;
    end else if (!stopped) begin
      if (brk) begin
        cur_shift_next = s_brk;
        if (s_brk <= {1'b0, min_page_shift}) begin
          stopped_next = 1'b1;
        end else begin
          run_end_next = end_sum;
          tot_len_next = tot_sum;
        end
      end else begin
        run_end_next = end_sum;
        tot_len_next = tot_sum;
      end
    end else begin
      // Stopped region: entries up to the closing one change nothing.
    end
    if (seg.last_seg) begin
      first_pending_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= 1'b1;
      stopped       <= 1'b0;
      cur_shift     <= slps_pkg::MAX_SHIFT;
      run_end       <= '0;
      region_start  <= '0;
      tot_len       <= '0;
    end else if (accept) begin
      first_pending <= first_pending_next;
      stopped       <= stopped_next;
      cur_shift     <= cur_shift_next;
      run_end       <= run_end_next;
      region_start  <= region_start_next;
      tot_len       <= tot_len_next;
    end
  end

  // Finish stage 1: capture the closed region
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= accept && seg.last_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_stopped <= stopped_next;
      b_shift   <= cur_shift_next;
      b_minsh   <= min_page_shift;
      b_end     <= run_end_next;
      b_tot     <= tot_len_next;
      b_region  <= region_start_next;
    end
  end

  // Finish stage 2: pad the first run down and the last run up to whole blocks
  logic [AW-1:0] b_mask, pad_head, pad_tail;

  assign b_mask   = slps_pkg::low_mask(b_shift);
  assign pad_head = b_region & b_mask;
  assign pad_tail = ((b_mask + AW'(1)) - (b_end & b_mask)) & b_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready) begin
      c_stopped <= b_stopped;
      c_shift   <= b_shift;
      c_shown   <= (b_shift < {1'b0, b_minsh}) ? b_minsh : b_shift[BW-1:0];
      c_total   <= b_tot + pad_head + pad_tail;
    end
  end

  // Output register: count and remainder test
  logic [AW-1:0] c_count;
  logic          c_rem;

  assign c_count = c_total >> c_shift;
  assign c_rem   = |(c_total & slps_pkg::low_mask(c_shift));

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (o_ready) begin
      res.valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready) begin
      res.xlat_shift  <= c_shown;
      res.mtt_count   <= c_stopped ? '0 : c_count[slps_pkg::COUNT_W-1:0];
      res.count_valid <= !c_stopped;
      res.misaligned  <= !c_stopped && c_rem;
    end
  end

endmodule

// ===== hw/rtl/slps_checker.sv =====
// Port-level assertions for the block-shift core, bound to its top level.
module slps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            seg_ready,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [slps_pkg::BSHIFT_W-1:0]   xlat_shift,
  input logic [slps_pkg::COUNT_W-1:0]    mtt_count,
  input logic                            count_valid,
  input logic                            misaligned
);

  // Stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(xlat_shift) &&
      $stable(mtt_count) && $stable(count_valid) && $stable(misaligned))
    else $error("result word changed while stalled");

  // Stopped region carries no count and no misalignment
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !count_valid |-> mtt_count == '0 && !misaligned)
    else $error("stopped region reported a count");

  // Reset empties the finishing pipeline
  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid && seg_ready)
    else $error("pipeline not empty after reset");

  // Input only backs up while a result is held
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !seg_ready |-> res_valid && !res_ready)
    else $error("input stalled without output backpressure");

endmodule

bind scatter_list_translation_page_size_core slps_checker u_slps_checker (
  .clk         (clk),
  .rst         (rst),
  .seg_ready   (seg.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .xlat_shift  (res.xlat_shift),
  .mtt_count   (res.mtt_count),
  .count_valid (res.count_valid),
  .misaligned  (res.misaligned)
);
